>>> rtl/assert_macros.svh
// Assertion macros for the button classifier RTL.
// Depends on nothing; simulation sees the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MCB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MCB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MCB_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MCB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/mcb_pkg.sv
// Types and constants of the multi-click button classifier.
// Used by the event and register interfaces, the register file, the core and the top level.
package mcb_pkg;

  localparam int unsigned CFG_BITS  = 16;
  localparam int unsigned CODE_BITS = 8;
  localparam int unsigned IDX_BITS  = 8;
  localparam int unsigned CNT_BITS  = 3;

  localparam logic [CNT_BITS-1:0] COUNT_MAX = 3'd7;

  localparam logic [CFG_BITS-1:0]  MIN_PULSE_RST  = 16'd20;
  localparam logic [CFG_BITS-1:0]  LONG_PRESS_RST = 16'd500;
  localparam logic [CFG_BITS-1:0]  MAX_GAP_RST    = 16'd150;
  localparam logic [CODE_BITS-1:0] EVENT_BASE_RST = 8'd1;

  typedef enum logic [IDX_BITS-1:0] {
    REG_MIN_PULSE  = 8'd0,
    REG_LONG_PRESS = 8'd1,
    REG_MAX_GAP    = 8'd2,
    REG_EVENT_BASE = 8'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_CLICK  = 3'd0,
    KIND_DOUBLE = 3'd1,
    KIND_TRIPLE = 3'd2,
    KIND_LONG   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [CFG_BITS-1:0]  min_pulse_ticks;
    logic [CFG_BITS-1:0]  long_press_ticks;
    logic [CFG_BITS-1:0]  max_gap_ticks;
    logic [CODE_BITS-1:0] event_base;
  } cfg_t;

endpackage

>>> rtl/mcb_btn_if.sv
// Button sample channel: valid/ready with the sampled level.
// Depends on nothing.
interface mcb_btn_if;
  logic valid;
  logic ready;
  logic button_pressed;
  modport source (output valid, output button_pressed, input ready);
  modport sink (input valid, input button_pressed, output ready);
endinterface

>>> rtl/mcb_evt_if.sv
// Event result channel: valid/ready with the event code.
// Depends on mcb_pkg for the code width.
interface mcb_evt_if;
  logic valid;
  logic ready;
  logic [mcb_pkg::CODE_BITS-1:0] event_code;
  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

>>> rtl/mcb_cfg_if.sv
// Register write channel: valid/ready with register index and write data.
// Depends on mcb_pkg for the index and data widths.
interface mcb_cfg_if;
  logic valid;
  logic ready;
  logic [mcb_pkg::IDX_BITS-1:0] index;
  logic [mcb_pkg::CFG_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/multi_click_button_classifier_unit.sv
// Multi-click / long-press button classifier, top level.
// Depends on mcb_pkg, the three channel interfaces, mcb_regs and mcb_core.
//
//   channel  dir  payload            beat
//   button   in   button_pressed     one tick sample
//   result   out  event_code         one code per tick, 0 = none
//   cfg      in   index, data        one register write
//
// One tick enters the input register per cycle while it has room; it is classified
// on the way into the result register, which then holds its code.
// The two registers let a new tick enter while a code waits for ready.
// A stalled result holds both stages; cfg is always ready.
// Reset clears both stages and the tracking state to "released long ago".
module multi_click_button_classifier_unit #(
  parameter int unsigned AGE_BITS = 16
) (
  input logic     clk,
  input logic     rst,
  mcb_btn_if.sink button,
  mcb_evt_if.source result,
  mcb_cfg_if.sink cfg
);
  import mcb_pkg::*;

  `include "assert_macros.svh"

  cfg_t                 cfg_q;
  logic                 s1_valid;
  logic                 s1_level;
  logic                 s2_valid;
  logic [CODE_BITS-1:0] s2_code;
  logic [CODE_BITS-1:0] code;
  logic                 advance;
  logic                 take;

  mcb_regs u_regs (
    .clk (clk),
    .rst (rst),
    .wr  (cfg),
    .cfg (cfg_q)
  );

  mcb_core #(
    .AGE_BITS (AGE_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .now  (s1_level),
    .cfg  (cfg_q),
    .code (code)
  );

  assign advance      = s1_valid && (!s2_valid || result.ready);
  assign button.ready = !s1_valid || advance;
  assign take         = button.valid && button.ready;

  assign result.valid      = s2_valid;
  assign result.event_code = s2_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        s2_valid <= 1'b1;
      end else if (result.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_level <= button.button_pressed;
    end
    if (advance) begin
      s2_code <= code;
    end
  end

  `MCB_ASSERT_NEXT(a_take_fills, clk, rst, take, s1_valid)
  `MCB_ASSERT_NEXT(a_held_stays, clk, rst, s1_valid && !advance, s1_valid && $stable(s1_level))
  `MCB_ASSERT_NEXT(a_advance_fills, clk, rst, advance, s2_valid)
  `MCB_ASSERT_NOW(a_no_overrun, clk, rst, s2_valid && !result.ready, !advance)

endmodule

>>> rtl/mcb_regs.sv
// Configuration register file of the button classifier.
// Depends on mcb_pkg and mcb_cfg_if.
module mcb_regs (
  input  logic          clk,
  input  logic          rst,
  mcb_cfg_if.sink       wr,
  output mcb_pkg::cfg_t cfg
);
  import mcb_pkg::*;

  cfg_t regs;

  assign wr.ready = 1'b1;
  assign cfg      = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_pulse_ticks  <= MIN_PULSE_RST;
      regs.long_press_ticks <= LONG_PRESS_RST;
      regs.max_gap_ticks    <= MAX_GAP_RST;
      regs.event_base       <= EVENT_BASE_RST;
    end else if (wr.valid && wr.ready) begin
      unique case (reg_idx_t'(wr.index))
        REG_MIN_PULSE:  regs.min_pulse_ticks  <= wr.data;
        REG_LONG_PRESS: regs.long_press_ticks <= wr.data;
        REG_MAX_GAP:    regs.max_gap_ticks    <= wr.data;
        REG_EVENT_BASE: regs.event_base       <= wr.data[CODE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/mcb_core.sv
// Press/release tracking state and per-tick event decision.
// Depends on mcb_pkg; advances once per step pulse.
module mcb_core #(
  parameter int unsigned AGE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           now,
  input  mcb_pkg::cfg_t                  cfg,
  output logic [mcb_pkg::CODE_BITS-1:0]  code
);
  import mcb_pkg::*;

  localparam int unsigned CMP_BITS = (AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS;

  logic                level;
  logic [AGE_BITS-1:0] press_age;
  logic [AGE_BITS-1:0] release_age;
  logic [CNT_BITS-1:0] short_count;
  logic                long_reported;

  logic                level_next;
  logic [AGE_BITS-1:0] press_age_next;
  logic [AGE_BITS-1:0] release_age_next;
  logic [CNT_BITS-1:0] short_count_next;
  logic                long_reported_next;

  logic [AGE_BITS-1:0] pa_adv;
  logic [AGE_BITS-1:0] ra_adv;
  logic [CMP_BITS-1:0] pa_adv_x;
  logic [CMP_BITS-1:0] pa_new_x;
  logic [CMP_BITS-1:0] ra_new_x;
  logic [CMP_BITS-1:0] min_x;
  logic [CMP_BITS-1:0] long_x;
  logic [CMP_BITS-1:0] gap_x;
  logic [CNT_BITS-1:0] cnt_mid;
  logic                emit;
  kind_t               kind;

  assign pa_adv = (&press_age)   ? press_age   : press_age + 1'b1;
  assign ra_adv = (&release_age) ? release_age : release_age + 1'b1;

  assign min_x    = CMP_BITS'(cfg.min_pulse_ticks);
  assign long_x   = CMP_BITS'(cfg.long_press_ticks);
  assign gap_x    = CMP_BITS'(cfg.max_gap_ticks);
  assign pa_adv_x = CMP_BITS'(pa_adv);

  always_comb begin
    press_age_next   = (now && !level) ? '0 : pa_adv;
    release_age_next = (!now && level) ? '0 : ra_adv;
    cnt_mid          = short_count;
    if (!now && level && pa_adv_x > min_x && pa_adv_x < long_x && short_count != COUNT_MAX) begin
      cnt_mid = short_count + 1'b1;
    end
  end

  assign pa_new_x = CMP_BITS'(press_age_next);
  assign ra_new_x = CMP_BITS'(release_age_next);

  always_comb begin
    level_next         = now;
    short_count_next   = cnt_mid;
    long_reported_next = long_reported;
    emit               = 1'b0;
    kind               = KIND_CLICK;
    if (!now) begin
      if (ra_new_x > gap_x) begin
        short_count_next   = '0;
        long_reported_next = 1'b0;
        unique case (cnt_mid)
          3'd1: begin emit = 1'b1; kind = KIND_CLICK;  end
          3'd2: begin emit = 1'b1; kind = KIND_DOUBLE; end
          3'd3: begin emit = 1'b1; kind = KIND_TRIPLE; end
          default: ;
        endcase
      end
    end else if (pa_new_x > long_x && !long_reported) begin
      long_reported_next = 1'b1;
      short_count_next   = '0;
      emit               = 1'b1;
      kind               = KIND_LONG;
    end
  end

  assign code = emit ? (cfg.event_base + CODE_BITS'(kind)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= 1'b0;
      press_age     <= '0;
      release_age   <= '1;
      short_count   <= '0;
      long_reported <= 1'b0;
    end else if (step) begin
      level         <= level_next;
      press_age     <= press_age_next;
      release_age   <= release_age_next;
      short_count   <= short_count_next;
      long_reported <= long_reported_next;
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the multi-click / long-press button classifier.
// Depends on mcb_pkg, the three channel interfaces and multi_click_button_classifier_unit.
// Ticks stream in through a queue-fed driver; each returned event code is checked in order.
module testbench;
  import mcb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AGE_BITS = 16;
  localparam logic [AGE_BITS-1:0] AGE_TOP = {AGE_BITS{1'b1}};
  localparam logic [IDX_BITS-1:0] FIRST_UNMAPPED = REG_EVENT_BASE + 1'b1;
  localparam logic [IDX_BITS-1:0] LAST_INDEX = {IDX_BITS{1'b1}};
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTINGS_RUNS = 6;
  localparam int TICKS_PER_SETTING = 50;

  logic clk;
  logic rst;

  mcb_btn_if btn_ch ();
  mcb_evt_if evt_ch ();
  mcb_cfg_if reg_ch ();

  multi_click_button_classifier_unit #(
    .AGE_BITS(AGE_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .button(btn_ch),
    .result(evt_ch),
    .cfg(reg_ch)
  );

  cfg_t thresholds;
  logic level_now;
  logic [AGE_BITS-1:0] press_age;
  logic [AGE_BITS-1:0] release_age;
  logic [CNT_BITS-1:0] pulse_count;
  logic long_sent;

  logic tick_queue[$];
  logic [CODE_BITS-1:0] expected_codes[$];

  bit calm;
  int hold_asked;
  int hold_granted;
  int hold_left;
  int mismatches;
  int ticks_queued;
  int ticks_sent;
  int codes_checked;
  int events_seen;
  int regs_written;
  int quiet_cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic bit take_gap();
    return !calm && ($urandom_range(0, 99) < 28);
  endfunction

  function automatic logic [CODE_BITS-1:0] classify_tick(input logic now);
    logic [CODE_BITS-1:0] code;
    code = '0;
    if (press_age != AGE_TOP) press_age = press_age + 1'b1;
    if (release_age != AGE_TOP) release_age = release_age + 1'b1;
    if (now != level_now) begin
      if (now) begin
        press_age = '0;
      end else begin
        if (press_age > thresholds.min_pulse_ticks && press_age < thresholds.long_press_ticks
            && pulse_count != COUNT_MAX)
          pulse_count = pulse_count + 1'b1;
        release_age = '0;
      end
      level_now = now;
    end
    if (!level_now) begin
      if (release_age > thresholds.max_gap_ticks) begin
        case (pulse_count)
          3'd1: code = thresholds.event_base + KIND_CLICK;
          3'd2: code = thresholds.event_base + KIND_DOUBLE;
          3'd3: code = thresholds.event_base + KIND_TRIPLE;
          default: ;
        endcase
        pulse_count = '0;
        long_sent = 1'b0;
      end
    end else if (press_age > thresholds.long_press_ticks && !long_sent) begin
      long_sent = 1'b1;
      pulse_count = '0;
      code = thresholds.event_base + KIND_LONG;
    end
    return code;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 20) $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // driver: hold a beat until ready, then advance to the next queued tick
  always @(posedge clk) begin
    if (rst) begin
      btn_ch.valid <= 1'b0;
    end else begin
      if (btn_ch.valid && btn_ch.ready) begin
        expected_codes.push_back(classify_tick(btn_ch.button_pressed));
        ticks_sent++;
      end
      if (!btn_ch.valid || btn_ch.ready) begin
        if (tick_queue.size() > 0 && !take_gap()) begin
          btn_ch.valid <= 1'b1;
          btn_ch.button_pressed <= tick_queue.pop_front();
        end else begin
          btn_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (!rst && evt_ch.valid && evt_ch.ready) begin
      if (expected_codes.size() == 0) begin
        report_mismatch($sformatf("event code %0d with no tick pending", evt_ch.event_code));
      end else begin
        if (evt_ch.event_code !== expected_codes[0])
          report_mismatch($sformatf("event_code %0d, expected %0d",
                                    evt_ch.event_code, expected_codes[0]));
        if (expected_codes[0] != '0) events_seen++;
        void'(expected_codes.pop_front());
        codes_checked++;
      end
    end
    if (rst) begin
      evt_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      evt_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_asked != hold_granted) begin
      hold_granted = hold_asked;
      hold_left = HOLD_CYCLES;
      evt_ch.ready <= 1'b0;
    end else begin
      evt_ch.ready <= !take_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (btn_ch.valid && btn_ch.ready) || (evt_ch.valid && evt_ch.ready)
        || (reg_ch.valid && reg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d codes outstanding",
               quiet_cycles, expected_codes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_run(input logic lvl, input int n);
    repeat (n) tick_queue.push_back(lvl);
    ticks_queued += n;
  endtask

  task automatic push_pulses(input int count, input int press_len, input int gap_len);
    repeat (count) begin
      push_run(1'b1, press_len);
      push_run(1'b0, gap_len);
    end
  endtask

  task automatic settle();
    while (tick_queue.size() != 0 || btn_ch.valid || expected_codes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data <= val;
    @(posedge clk);
    while (!reg_ch.ready) @(posedge clk);
    reg_ch.valid <= 1'b0;
    case (idx)
      REG_MIN_PULSE: thresholds.min_pulse_ticks = val;
      REG_LONG_PRESS: thresholds.long_press_ticks = val;
      REG_MAX_GAP: thresholds.max_gap_ticks = val;
      REG_EVENT_BASE: thresholds.event_base = val[CODE_BITS-1:0];
      default: ;
    endcase
    regs_written++;
    @(posedge clk);
  endtask

  task automatic set_all(input logic [CFG_BITS-1:0] min_t, input logic [CFG_BITS-1:0] long_t,
                         input logic [CFG_BITS-1:0] gap_t, input logic [CFG_BITS-1:0] base);
    write_reg(REG_MIN_PULSE, min_t);
    write_reg(REG_LONG_PRESS, long_t);
    write_reg(REG_MAX_GAP, gap_t);
    write_reg(REG_EVENT_BASE, base);
  endtask

  task automatic push_random_sequences(input int n);
    int stop_at;
    int p_hi;
    int g_hi;
    stop_at = ticks_queued + n;
    p_hi = (thresholds.long_press_ticks > 16) ? 20 : thresholds.long_press_ticks + 3;
    g_hi = (thresholds.max_gap_ticks > 16) ? 20 : thresholds.max_gap_ticks + 3;
    while (ticks_queued < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        push_run(1'b1, $urandom_range(1, p_hi));
        push_run(1'b0, $urandom_range(1, g_hi));
      end else begin
        repeat ($urandom_range(1, 4)) push_run($urandom_range(0, 1), 1);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    btn_ch.valid = 1'b0;
    btn_ch.button_pressed = 1'b0;
    evt_ch.ready = 1'b0;
    reg_ch.valid = 1'b0;
    reg_ch.index = '0;
    reg_ch.data = '0;
    calm = 1'b0;
    hold_asked = 0;
    hold_granted = 0;
    hold_left = 0;
    mismatches = 0;
    ticks_queued = 0;
    ticks_sent = 0;
    codes_checked = 0;
    events_seen = 0;
    regs_written = 0;
    quiet_cycles = 0;
    thresholds.min_pulse_ticks = MIN_PULSE_RST;
    thresholds.long_press_ticks = LONG_PRESS_RST;
    thresholds.max_gap_ticks = MAX_GAP_RST;
    thresholds.event_base = EVENT_BASE_RST;
    level_now = 1'b0;
    press_age = '0;
    release_age = AGE_TOP;
    pulse_count = '0;
    long_sent = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    push_run(1'b1, 30);
    push_run(1'b0, 160);
    push_run(1'b1, 3);
    push_run(1'b0, 2);
    settle();

    calm = 1'b1;
    set_all(16'd2, 16'd8, 16'd4, 16'd1);
    write_reg(IDX_BITS'($urandom_range(FIRST_UNMAPPED, LAST_INDEX)), 16'hFFFF);
    write_reg(LAST_INDEX, 16'h0000);
    push_pulses(1, 4, 6);
    push_pulses(2, 4, 2);
    push_run(1'b0, 4);
    push_pulses(3, 3, 1);
    push_run(1'b0, 5);
    push_pulses(4, 5, 3);
    push_run(1'b0, 5);
    push_pulses(8, 4, 2);
    push_run(1'b0, 5);
    push_pulses(1, 2, 6);
    push_pulses(1, 8, 6);
    push_pulses(1, 12, 6);
    push_pulses(1, 4, 2);
    push_pulses(1, 12, 6);
    settle();
    calm = 1'b0;

    write_reg(REG_EVENT_BASE, 16'd251);
    push_pulses(1, 11, 6);
    settle();
    write_reg(REG_EVENT_BASE, 16'd252);
    push_pulses(1, 11, 6);
    settle();
    write_reg(REG_EVENT_BASE, 16'hFFFF);
    push_pulses(1, 4, 6);
    push_pulses(2, 4, 2);
    push_run(1'b0, 5);
    settle();
    write_reg(REG_EVENT_BASE, 16'hAB00);
    push_pulses(1, 4, 6);
    settle();

    set_all(16'd0, 16'hFFFF, 16'd0, 16'd7);
    push_pulses(3, 1, 2);
    push_run(1'b1, 40);
    push_run(1'b0, 3);
    settle();
    set_all(16'hFFFF, 16'd0, 16'd3, 16'd100);
    push_pulses(2, 3, 5);
    push_run(1'b1, 1);
    push_run(1'b0, 5);
    settle();

    for (int s = 0; s < SETTINGS_RUNS; s++) begin
      if (s == SETTINGS_RUNS - 1)
        set_all(16'd0, 16'hFFFF, 16'd0, 16'($urandom_range(0, 65535)));
      else
        set_all(16'($urandom_range(0, 5)), 16'($urandom_range(0, 14)),
                16'($urandom_range(0, 8)), 16'($urandom_range(0, 65535)));
      calm = (s == 3);
      if (s == 2) hold_asked++;
      push_random_sequences(TICKS_PER_SETTING);
      if (s == 4) begin
        @(posedge clk);
        hold_asked++;
        push_random_sequences(TICKS_PER_SETTING / 2);
      end
      settle();
    end
    calm = 1'b0;

    while (expected_codes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d ticks and %0d checked codes (%0d events), %0d register writes,",
             ticks_sent, codes_checked, events_seen, regs_written);
    $display("with code wrap, pulse count overflow, unmapped writes and %0d result hold-offs.",
             hold_granted);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
